// ===== sv/psc_pkg.sv =====
package psc_pkg;

  // field widths
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned OUT_W   = 32;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_PRESENT   = 4'd0;
  localparam logic [IDX_W-1:0] REG_WORD_ZERO = 4'd1;
  localparam logic [IDX_W-1:0] REG_SENS      = 4'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 4'd3;
  localparam logic [IDX_W-1:0] REG_SENS_TC   = 4'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET_TC = 4'd5;
  localparam logic [IDX_W-1:0] REG_TREF      = 4'd6;
  localparam logic [IDX_W-1:0] REG_TEMPSENS  = 4'd7;

  // internal widths, sized for the worst case of raw and calibration values
  localparam int unsigned DT_W   = RAW_W + 1;          // d2 - c5 * 256
  localparam int unsigned PDT_W  = DT_W + COEF_W + 1;  // dt times one coefficient
  localparam int unsigned DD_W   = 2 * DT_W;           // dt squared
  localparam int unsigned TEMP_W = 20;
  localparam int unsigned T2_W   = 18;
  localparam int unsigned WIDE_W = 40;                 // off, sens and their corrections
  localparam int unsigned SPLIT  = 20;                 // low part of sens in the d1 product
  localparam int unsigned PLO_W  = RAW_W + SPLIT;
  localparam int unsigned PHI_W  = RAW_W + 1 + WIDE_W - SPLIT;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned X_W    = 45;

  // scale factors as shift counts
  localparam int unsigned TREF_SH     = 8;
  localparam int unsigned DIV_TEMP_SH = 23;
  localparam int unsigned OFF_SH      = 16;
  localparam int unsigned DIV_OFF_SH  = 7;
  localparam int unsigned SENS_SH     = 15;
  localparam int unsigned DIV_SENS_SH = 8;
  localparam int unsigned T2_SH       = 33;
  localparam int unsigned DIV_P1_SH   = 21;
  localparam int unsigned DIV_P2_SH   = 13;

  // temperature thresholds in 0.01 C
  localparam int TEMP_REF      = 2000;
  localparam int TEMP_VERY_LOW = -1500;
  localparam int VLOW_LIMIT    = TEMP_VERY_LOW - TEMP_REF;
  localparam int VC_BIAS       = TEMP_REF - TEMP_VERY_LOW;

  localparam int unsigned NUM_STAGES = 10;

  typedef struct packed {
    logic              not_present;
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } coef_t;

  // signed division by 2^sh, truncating toward zero
  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (x + bias) >>> sh;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[OUT_W-1:0];
  endfunction

endpackage

// ===== sv/psc_sample_if.sv =====
interface psc_sample_if import psc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== sv/psc_result_if.sv =====
interface psc_result_if import psc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    status;
  logic signed [OUT_W-1:0] temperature_centi;
  logic signed [OUT_W-1:0] pressure_decimbar;

  modport source (output valid, output status, output temperature_centi,
                  output pressure_decimbar, input ready);
  modport sink   (input valid, input status, input temperature_centi,
                  input pressure_decimbar, output ready);
endinterface

// ===== sv/psc_cfg_if.sv =====
interface psc_cfg_if import psc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [COEF_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/psc_regs.sv =====
module psc_regs import psc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  psc_cfg_if.sink cfg_i,
  output coef_t coef_o
);

  logic              present_q;
  logic [COEF_W-1:0] word0_q;
  logic [COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      word0_q   <= '0;
      c1_q      <= '0;
      c2_q      <= '0;
      c3_q      <= '0;
      c4_q      <= '0;
      c5_q      <= '0;
      c6_q      <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PRESENT:   present_q <= cfg_i.data[0];
        REG_WORD_ZERO: word0_q   <= cfg_i.data;
        REG_SENS:      c1_q      <= cfg_i.data;
        REG_OFFSET:    c2_q      <= cfg_i.data;
        REG_SENS_TC:   c3_q      <= cfg_i.data;
        REG_OFFSET_TC: c4_q      <= cfg_i.data;
        REG_TREF:      c5_q      <= cfg_i.data;
        REG_TEMPSENS:  c6_q      <= cfg_i.data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // missing sensor or blank calibration words
  assign coef_o.not_present = !present_q || (word0_q == '0) || (c1_q == '0) || (c2_q == '0);
  assign coef_o.c1 = c1_q;
  assign coef_o.c2 = c2_q;
  assign coef_o.c3 = c3_q;
  assign coef_o.c4 = c4_q;
  assign coef_o.c5 = c5_q;
  assign coef_o.c6 = c6_q;

endmodule

// ===== sv/pressure_sensor_compensation.sv =====
// Pressure sensor compensation: turns one pair of 24-bit raw conversions
// (pressure D1, temperature D2) into temperature in 0.01 C and pressure in
// 0.1 mbar, with first-order compensation and the second-order correction
// below 20 C (extra term below -15 C).
// Channels: sample_i takes a request of raw_pressure/raw_temperature,
// result_o gives status, temperature_centi and pressure_decimbar; both are
// valid/ready, a request moves when valid and ready are high at a clock edge.
// cfg_i writes the calibration registers by index (0 present flag, 1 word
// zero, 2..7 calibration words one to six); it is always ready and is to be
// written only while no request is in flight.
// Throughput: one request per cycle while result_o takes results, from a
// 10-stage pipeline; the d1 by sens product is split over two stages.
// Reset clears the registers (status reads not present) and empties the
// pipeline. When result_o stalls, each stage holds only if the stage after it
// is full, so bubbles close up and sample_i stays ready until all stages fill.
module pressure_sensor_compensation import psc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  psc_sample_if.sink   sample_i,
  psc_result_if.source result_o,
  psc_cfg_if.sink      cfg_i
);

  coef_t coef;

  psc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  // ---------------------------------------------------------------------------
  // pipeline control: stage k loads when it is empty or stage k+1 moves
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES:1] v_q;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !v_q[NUM_STAGES] || result_o.ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign sample_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= sample_i.valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: dt = d2 - c5 * 256
  // ---------------------------------------------------------------------------
  logic                   s1_np_q;
  logic [RAW_W-1:0]       s1_d1_q;
  logic signed [DT_W-1:0] s1_dt_q;
  logic signed [DT_W-1:0] dt_d;

  assign dt_d = $signed({1'b0, sample_i.raw_temperature})
              - $signed({1'b0, coef.c5, {TREF_SH{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_np_q <= coef.not_present;
      s1_d1_q <= sample_i.raw_pressure;
      s1_dt_q <= dt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: the four products on dt
  // ---------------------------------------------------------------------------
  logic                    s2_np_q;
  logic [RAW_W-1:0]        s2_d1_q;
  logic signed [PDT_W-1:0] s2_pt_q, s2_po_q, s2_ps_q;
  logic signed [DD_W-1:0]  s2_dd_q;
  logic signed [COEF_W:0]  c3s, c4s, c6s;

  assign c3s = $signed({1'b0, coef.c3});
  assign c4s = $signed({1'b0, coef.c4});
  assign c6s = $signed({1'b0, coef.c6});

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_np_q <= s1_np_q;
      s2_d1_q <= s1_d1_q;
      s2_pt_q <= PDT_W'(s1_dt_q) * PDT_W'(c6s);
      s2_po_q <= PDT_W'(s1_dt_q) * PDT_W'(c4s);
      s2_ps_q <= PDT_W'(s1_dt_q) * PDT_W'(c3s);
      s2_dd_q <= DD_W'(s1_dt_q) * DD_W'(s1_dt_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: first-order temp, off, sens and the t2 term
  // ---------------------------------------------------------------------------
  logic                     s3_np_q;
  logic [RAW_W-1:0]         s3_d1_q;
  logic signed [TEMP_W-1:0] s3_lo_q, s3_temp1_q;
  logic signed [WIDE_W-1:0] s3_off1_q, s3_sens1_q;
  logic [T2_W-1:0]          s3_t2_q;

  logic signed [63:0]       tq, oq, sq;
  logic signed [TEMP_W-1:0] lo_d, temp1_d;
  logic signed [WIDE_W-1:0] off1_d, sens1_d;
  logic [DD_W:0]            dd3;
  logic [T2_W-1:0]          t2_d;

  always_comb begin
    tq      = sdiv_pow2(64'(s2_pt_q), DIV_TEMP_SH);
    oq      = sdiv_pow2(64'(s2_po_q), DIV_OFF_SH);
    sq      = sdiv_pow2(64'(s2_ps_q), DIV_SENS_SH);
    // lo is temp - 2000, i.e. the quotient alone
    lo_d    = $signed(tq[TEMP_W-1:0]);
    temp1_d = TEMP_W'(TEMP_REF) + lo_d;
    off1_d  = WIDE_W'($signed({1'b0, coef.c2, {OFF_SH{1'b0}}})) + $signed(oq[WIDE_W-1:0]);
    sens1_d = WIDE_W'($signed({1'b0, coef.c1, {SENS_SH{1'b0}}})) + $signed(sq[WIDE_W-1:0]);
    // dt squared is never negative, so the division is a plain shift
    dd3     = (DD_W+1)'($unsigned(s2_dd_q)) + ((DD_W+1)'($unsigned(s2_dd_q)) << 1);
    t2_d    = T2_W'(dd3 >> T2_SH);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_np_q    <= s2_np_q;
      s3_d1_q    <= s2_d1_q;
      s3_lo_q    <= lo_d;
      s3_temp1_q <= temp1_d;
      s3_off1_q  <= off1_d;
      s3_sens1_q <= sens1_d;
      s3_t2_q    <= t2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: squares for the second-order terms, final temperature
  // ---------------------------------------------------------------------------
  logic                     s4_np_q, s4_low_q, s4_vlow_q;
  logic [RAW_W-1:0]         s4_d1_q;
  logic signed [TEMP_W-1:0] s4_temp2_q;
  logic signed [WIDE_W-1:0] s4_lo2_q, s4_vc2_q, s4_off1_q, s4_sens1_q;

  logic signed [TEMP_W-1:0] vc;
  logic                     low_d;

  assign vc    = s3_lo_q + TEMP_W'(VC_BIAS);
  assign low_d = s3_lo_q[TEMP_W-1];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_np_q    <= s3_np_q;
      s4_d1_q    <= s3_d1_q;
      s4_low_q   <= low_d;
      s4_vlow_q  <= s3_lo_q < TEMP_W'(VLOW_LIMIT);
      s4_lo2_q   <= WIDE_W'(s3_lo_q) * WIDE_W'(s3_lo_q);
      s4_vc2_q   <= WIDE_W'(vc) * WIDE_W'(vc);
      s4_temp2_q <= low_d ? s3_temp1_q - $signed({2'b00, s3_t2_q}) : s3_temp1_q;
      s4_off1_q  <= s3_off1_q;
      s4_sens1_q <= s3_sens1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: off2 = 3 lo^2 / 2 (+ 7 vc^2), sens2 = 5 lo^2 / 8 (+ 4 vc^2)
  // ---------------------------------------------------------------------------
  logic                     s5_np_q;
  logic [RAW_W-1:0]         s5_d1_q;
  logic signed [TEMP_W-1:0] s5_temp2_q;
  logic signed [WIDE_W-1:0] s5_off1_q, s5_sens1_q;
  logic [WIDE_W-1:0]        s5_off2_q, s5_sens2_q;

  logic [WIDE_W-1:0] lo2u, vc2u, off2_d, sens2_d;

  always_comb begin
    lo2u    = $unsigned(s4_lo2_q);
    vc2u    = $unsigned(s4_vc2_q);
    off2_d  = '0;
    sens2_d = '0;
    if (s4_low_q) begin
      off2_d  = (lo2u + (lo2u << 1)) >> 1;
      sens2_d = ((lo2u << 2) + lo2u) >> 3;
      if (s4_vlow_q) begin
        off2_d  = off2_d + ((vc2u << 3) - vc2u);
        sens2_d = sens2_d + (vc2u << 2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_np_q    <= s4_np_q;
      s5_d1_q    <= s4_d1_q;
      s5_temp2_q <= s4_temp2_q;
      s5_off1_q  <= s4_off1_q;
      s5_sens1_q <= s4_sens1_q;
      s5_off2_q  <= off2_d;
      s5_sens2_q <= sens2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: corrected off and sens
  // ---------------------------------------------------------------------------
  logic                     s6_np_q;
  logic [RAW_W-1:0]         s6_d1_q;
  logic signed [TEMP_W-1:0] s6_temp2_q;
  logic signed [WIDE_W-1:0] s6_off_q, s6_sens_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_np_q    <= s5_np_q;
      s6_d1_q    <= s5_d1_q;
      s6_temp2_q <= s5_temp2_q;
      s6_off_q   <= s5_off1_q - $signed(s5_off2_q);
      s6_sens_q  <= s5_sens1_q - $signed(s5_sens2_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: d1 * sens as two partial products
  // ---------------------------------------------------------------------------
  logic                     s7_np_q;
  logic signed [TEMP_W-1:0] s7_temp2_q;
  logic signed [WIDE_W-1:0] s7_off_q;
  logic [PLO_W-1:0]         s7_plo_q;
  logic signed [PHI_W-1:0]  s7_phi_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_np_q    <= s6_np_q;
      s7_temp2_q <= s6_temp2_q;
      s7_off_q   <= s6_off_q;
      s7_plo_q   <= PLO_W'(s6_d1_q) * PLO_W'(s6_sens_q[SPLIT-1:0]);
      s7_phi_q   <= PHI_W'($signed({1'b0, s6_d1_q}))
                  * PHI_W'($signed(s6_sens_q[WIDE_W-1:SPLIT]));
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: combine partial products
  // ---------------------------------------------------------------------------
  logic                     s8_np_q;
  logic signed [TEMP_W-1:0] s8_temp2_q;
  logic signed [WIDE_W-1:0] s8_off_q;
  logic signed [PROD_W-1:0] s8_prod_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_np_q    <= s7_np_q;
      s8_temp2_q <= s7_temp2_q;
      s8_off_q   <= s7_off_q;
      s8_prod_q  <= (PROD_W'(s7_phi_q) <<< SPLIT) + $signed(PROD_W'(s7_plo_q));
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: d1 * sens / 2^21 - off
  // ---------------------------------------------------------------------------
  logic                     s9_np_q;
  logic signed [TEMP_W-1:0] s9_temp2_q;
  logic signed [X_W-1:0]    s9_x_q;
  logic signed [63:0]       pq;

  assign pq = sdiv_pow2(s8_prod_q, DIV_P1_SH);

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_np_q    <= s8_np_q;
      s9_temp2_q <= s8_temp2_q;
      s9_x_q     <= $signed(pq[X_W-1:0]) - X_W'(s8_off_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 10: final divide, saturation, output register
  // ---------------------------------------------------------------------------
  logic                    s10_np_q;
  logic signed [OUT_W-1:0] s10_temp_q, s10_pres_q;
  logic signed [63:0]      pr;

  assign pr = sdiv_pow2(64'(s9_x_q), DIV_P2_SH);

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_np_q   <= s9_np_q;
      // results read zero when the sensor is not present
      s10_temp_q <= s9_np_q ? '0 : sat32(64'(s9_temp2_q));
      s10_pres_q <= s9_np_q ? '0 : sat32(pr);
    end
  end

  assign result_o.valid             = v_q[NUM_STAGES];
  assign result_o.status            = s10_np_q;
  assign result_o.temperature_centi = s10_temp_q;
  assign result_o.pressure_decimbar = s10_pres_q;

endmodule

// ===== test/tb_pressure_sensor_compensation.sv =====
module tb_pressure_sensor_compensation;
  import psc_pkg::*;

  // drain wait: the pipeline depth with slack on top
  localparam int LATENCY     = NUM_STAGES + 2;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int NUM_REGS    = int'(REG_TEMPSENS) + 1;
  localparam int IDLE_PCT    = 28;

  localparam logic [RAW_W-1:0] RAW_MAX = '1;

  // scale factors and divisors of the compensation formulas
  localparam longint TREF_SCALE = 64'sd256;
  localparam longint DIV_TEMP   = 64'sd8388608;
  localparam longint OFF_SCALE  = 64'sd65536;
  localparam longint DIV_OFF    = 64'sd128;
  localparam longint SENS_SCALE = 64'sd32768;
  localparam longint DIV_SENS   = 64'sd256;
  localparam longint DIV_P1     = 64'sd2097152;
  localparam longint DIV_P2     = 64'sd8192;
  localparam longint DIV_T2     = 64'sd8589934592;
  localparam longint I32_MAX    = 64'sd2147483647;
  localparam longint I32_MIN    = -64'sd2147483648;

  typedef struct packed {
    logic [RAW_W-1:0] pressure;
    logic [RAW_W-1:0] temperature;
  } raw_sample_t;

  typedef struct packed {
    logic                    status;
    logic signed [OUT_W-1:0] temperature_centi;
    logic signed [OUT_W-1:0] pressure_decimbar;
  } reading_t;

  // one full set of register values, in register order
  typedef struct packed {
    logic [COEF_W-1:0] present;
    logic [COEF_W-1:0] word_zero;
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_tc;
    logic [COEF_W-1:0] offset_tc;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tempsens;
  } calib_t;

  localparam calib_t CAL_TYPICAL = '{16'd1, 16'h0A5C, 16'd34982, 16'd36352,
                                     16'd20328, 16'd22354, 16'd26646, 16'd26146};
  localparam calib_t CAL_ALL_MAX = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
  localparam calib_t CAL_MINIMAL = '{16'd1, 16'd1, 16'd1, 16'd1,
                                     16'd0, 16'd0, 16'd0, 16'd0};
  // reference temperature at the top: most readings land far below -15 C
  localparam calib_t CAL_COLD    = '{16'd1, 16'd7, 16'd34982, 16'd36352,
                                     16'd20328, 16'd22354, 16'hFFFF, 16'hFFFF};
  // reference temperature at zero: readings land hot, no second order
  localparam calib_t CAL_HOT     = '{16'd1, 16'd7, 16'd40000, 16'd30000,
                                     16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF};

  logic clk_i;
  logic rst_ni;

  psc_sample_if sample_if ();
  psc_result_if result_if ();
  psc_cfg_if    cfg_if ();

  pressure_sensor_compensation dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // shadow of the calibration registers, present flag kept to its one bit
  logic [COEF_W-1:0] cal [NUM_REGS] = '{default: '0};

  raw_sample_t pending_samples [$];
  reading_t    expected_readings [$];
  raw_sample_t next_sample;
  reading_t    want;

  int unsigned queued_cnt  = 0;
  int unsigned checked_cnt = 0;
  int unsigned cycle_cnt   = 0;
  bit          failed      = 1'b0;
  // set for a stretch of the run with no idling on either side
  bit          steady      = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  function automatic logic signed [OUT_W-1:0] clamp32(input longint v);
    if (v > I32_MAX) begin
      return OUT_W'(I32_MAX);
    end else if (v < I32_MIN) begin
      return OUT_W'(I32_MIN);
    end
    return OUT_W'(v);
  endfunction

  function automatic longint pressure_from(input longint d1, input longint sens,
                                           input longint off);
    return ((d1 * sens) / DIV_P1 - off) / DIV_P2;
  endfunction

  // compensated reading for one raw pair under the current calibration
  function automatic reading_t compensate(input logic [RAW_W-1:0] raw_p,
                                          input logic [RAW_W-1:0] raw_t);
    longint   d1, d2, c1, c2, c3, c4, c5, c6;
    longint   dt, temp, off, sens, pres;
    longint   t2, lo, off2, sens2, vc;
    reading_t r;
    d1 = longint'(raw_p);
    d2 = longint'(raw_t);
    c1 = longint'(cal[REG_SENS]);
    c2 = longint'(cal[REG_OFFSET]);
    c3 = longint'(cal[REG_SENS_TC]);
    c4 = longint'(cal[REG_OFFSET_TC]);
    c5 = longint'(cal[REG_TREF]);
    c6 = longint'(cal[REG_TEMPSENS]);
    if (cal[REG_PRESENT] == '0 || cal[REG_WORD_ZERO] == '0 || c1 == 0 || c2 == 0) begin
      r.status            = 1'b1;
      r.temperature_centi = '0;
      r.pressure_decimbar = '0;
      return r;
    end
    dt   = d2 - c5 * TREF_SCALE;
    temp = TEMP_REF + (dt * c6) / DIV_TEMP;
    off  = c2 * OFF_SCALE + (c4 * dt) / DIV_OFF;
    sens = c1 * SENS_SCALE + (c3 * dt) / DIV_SENS;
    pres = pressure_from(d1, sens, off);
    // second order below 20 C, extra term below -15 C
    if (temp < TEMP_REF) begin
      t2    = (3 * dt * dt) / DIV_T2;
      lo    = temp - TEMP_REF;
      off2  = (3 * lo * lo) / 2;
      sens2 = (5 * lo * lo) / 8;
      if (temp < TEMP_VERY_LOW) begin
        vc    = temp - TEMP_VERY_LOW;
        off2  += 7 * vc * vc;
        sens2 += 4 * vc * vc;
      end
      temp -= t2;
      off  -= off2;
      sens -= sens2;
      pres = pressure_from(d1, sens, off);
    end
    r.status            = 1'b0;
    r.temperature_centi = clamp32(temp);
    r.pressure_decimbar = clamp32(pres);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // raw temperature that lands near a target in 0.01 C under the current calibration
  function automatic logic [RAW_W-1:0] raw_temp_for(input longint centi);
    longint d2;
    d2 = longint'(cal[REG_TREF]) * TREF_SCALE;
    if (cal[REG_TEMPSENS] != '0) begin
      d2 += (centi - TEMP_REF) * DIV_TEMP / longint'(cal[REG_TEMPSENS]);
    end
    if (d2 < 0) begin
      d2 = 0;
    end else if (d2 > longint'(RAW_MAX)) begin
      d2 = longint'(RAW_MAX);
    end
    return RAW_W'(d2);
  endfunction

  function automatic void queue_sample(input logic [RAW_W-1:0] p,
                                       input logic [RAW_W-1:0] t);
    pending_samples.push_back('{pressure: p, temperature: t});
    queued_cnt++;
  endfunction

  // raw extremes, the 20 C boundary and the -15 C boundary
  function automatic void queue_corners();
    queue_sample('0, '0);
    queue_sample(RAW_MAX, RAW_MAX);
    queue_sample('0, RAW_MAX);
    queue_sample(RAW_MAX, '0);
    queue_sample(RAW_W'($urandom), raw_temp_for(TEMP_REF));
    queue_sample(RAW_W'($urandom), raw_temp_for(TEMP_REF) - RAW_W'(1));
    queue_sample(RAW_MAX, raw_temp_for(TEMP_VERY_LOW));
    queue_sample(RAW_MAX, raw_temp_for(TEMP_VERY_LOW - 1));
  endfunction

  // half of the temperatures around the correction thresholds, the rest anywhere or at the raw extremes
  function automatic void queue_random();
    logic [RAW_W-1:0] p, t;
    p = RAW_W'($urandom);
    case ($urandom_range(7))
      0, 1, 2: t = RAW_W'($urandom);
      3, 4, 5: t = raw_temp_for(longint'($urandom_range(6500)) - 4500);
      6: t = raw_temp_for(TEMP_REF) + RAW_W'($urandom_range(64)) - RAW_W'(32);
      default: begin
        p = $urandom_range(1) ? RAW_MAX : '0;
        t = $urandom_range(1) ? RAW_MAX : '0;
      end
    endcase
    queue_sample(p, t);
  endfunction

  // caller stands at a rising edge; valid stays high for a following write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx <= REG_TEMPSENS) begin
      cal[idx] = (idx == REG_PRESENT) ? COEF_W'(val[0]) : val;
    end
  endtask

  task automatic program_all(input calib_t c);
    write_reg(REG_PRESENT, c.present);
    write_reg(REG_WORD_ZERO, c.word_zero);
    write_reg(REG_SENS, c.sens);
    write_reg(REG_OFFSET, c.offset);
    write_reg(REG_SENS_TC, c.sens_tc);
    write_reg(REG_OFFSET_TC, c.offset_tc);
    write_reg(REG_TREF, c.tref);
    write_reg(REG_TEMPSENS, c.tempsens);
  endtask

  // one batch of requests, then wait until the block has drained
  task automatic run_batch(input int count, input bit with_corners);
    cfg_if.valid <= 1'b0;
    if (with_corners) begin
      queue_corners();
    end
    repeat (count) queue_random();
    while (checked_cnt != queued_cnt) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // sample driver: one request per handshake, random gaps
  // ---------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
    end else begin
      // calibration is stable while requests are in flight, so predict now
      if (sample_if.valid && sample_if.ready) begin
        expected_readings.push_back(compensate(sample_if.raw_pressure,
                                               sample_if.raw_temperature));
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (pending_samples.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_sample = pending_samples.pop_front();
          sample_if.valid           <= 1'b1;
          sample_if.raw_pressure    <= next_sample.pressure;
          sample_if.raw_temperature <= next_sample.temperature;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result monitor: random back-pressure, in-order field compare
  // ---------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result: status %0d temperature_centi %0d pressure_decimbar %0d",
                 result_if.status, result_if.temperature_centi,
                 result_if.pressure_decimbar);
          failed = 1'b1;
        end else begin
          want = expected_readings.pop_front();
          if (result_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_if.status);
            failed = 1'b1;
          end
          if (result_if.temperature_centi !== want.temperature_centi) begin
            $error("temperature_centi: expected %0d, got %0d",
                   $signed(want.temperature_centi), result_if.temperature_centi);
            failed = 1'b1;
          end
          if (result_if.pressure_decimbar !== want.pressure_decimbar) begin
            $error("pressure_decimbar: expected %0d, got %0d",
                   $signed(want.pressure_decimbar), result_if.pressure_decimbar);
            failed = 1'b1;
          end
          checked_cnt++;
        end
      end
      result_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------

  initial begin
    sample_if.valid           = 1'b0;
    sample_if.raw_pressure    = '0;
    sample_if.raw_temperature = '0;
    result_if.ready           = 1'b0;
    cfg_if.valid              = 1'b0;
    cfg_if.index              = REG_PRESENT;
    cfg_if.data               = '0;
    rst_ni                    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset: every request reads not present
    run_batch(20, 1'b1);

    // datasheet-like calibration; writes past the last register must be dropped
    program_all(CAL_TYPICAL);
    for (int i = int'(REG_TEMPSENS) + 1; i < 2 ** IDX_W; i++) begin
      write_reg(IDX_W'(i), COEF_W'($urandom));
    end
    run_batch(100, 1'b1);

    // back-to-back stretch with both sides always willing
    steady = 1'b1;
    run_batch(100, 1'b0);
    steady = 1'b0;

    program_all(CAL_ALL_MAX);
    run_batch(100, 1'b1);

    program_all(CAL_MINIMAL);
    run_batch(60, 1'b0);

    program_all(CAL_COLD);
    run_batch(80, 1'b0);

    program_all(CAL_HOT);
    run_batch(60, 1'b0);

    // present flag keeps only its low bit
    write_reg(REG_PRESENT, 16'hFFFE);
    run_batch(20, 1'b0);

    // each required word zero in turn
    write_reg(REG_PRESENT, 16'h0001);
    write_reg(REG_WORD_ZERO, '0);
    run_batch(10, 1'b0);
    write_reg(REG_WORD_ZERO, 16'h8000);
    write_reg(REG_SENS, '0);
    run_batch(10, 1'b0);
    write_reg(REG_SENS, 16'd34982);
    write_reg(REG_OFFSET, '0);
    run_batch(10, 1'b0);

    // random calibrations
    repeat (3) begin
      program_all('{16'd1, COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                    COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                    COEF_W'($urandom)});
      run_batch(40, 1'b0);
    end

    if (expected_readings.size() != 0) begin
      $error("%0d results never arrived", expected_readings.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
